### sv/tplc_pkg.sv
// ----------------------------------------------------------------------------
// tplc_pkg: shared types and constants for the thermal protected load controller
// Event codes, field widths, limits and the word layouts passed between the
// front end and the state update.
// ----------------------------------------------------------------------------
package tplc_pkg;

    // Field widths
    localparam int OP_W       = 3;
    localparam int TEMP_W     = 12;
    localparam int MA_W       = 16;
    localparam int STEP_W     = 8;
    localparam int CUR_W      = 12;
    localparam int CUTOFF_W   = 11;
    localparam int INTERVAL_W = 16;

    // Stream word widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_CUTOFF   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL = 2'd1;

    localparam logic [CUTOFF_W-1:0]   CUTOFF_RESET   = 11'd600;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;

    // Current limits and encoder scaling
    localparam int MAX_CURRENT   = 4000;
    localparam int MIN_CURRENT   = 0;
    localparam int COARSE_FACTOR = 10;

    // Event codes
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_TEMPS   = 3'd1;
    localparam logic [OP_W-1:0] OP_SET     = 3'd2;
    localparam logic [OP_W-1:0] OP_ENABLE  = 3'd3;
    localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;
    localparam logic [OP_W-1:0] OP_TOGGLE  = 3'd5;
    localparam logic [OP_W-1:0] OP_STEPS   = 3'd6;
    localparam logic [OP_W-1:0] OP_HELD    = 3'd7;

    // One input event
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [TEMP_W-1:0] temp_a;
        logic signed [TEMP_W-1:0] temp_b;
        logic [MA_W-1:0]          setpoint_ma;
        logic signed [STEP_W-1:0] enc_steps;
        logic                     held_flag;
    } tplc_item_t;

    // One result word
    typedef struct packed {
        logic [CUR_W-1:0] dac_code;
        logic [CUR_W-1:0] set_current;
        logic             output_on;
        logic             fans_on;
        logic             emergency;
        logic             coarse_mode;
        logic             report_due;
    } tplc_result_t;

endpackage

### sv/tplc_core.sv
// ----------------------------------------------------------------------------
// tplc_core: controller state and per-event update
// Holds the load, fan, shutdown, encoder and tick state and works out the
// state and result word that one event leaves behind in combinational logic.
// ----------------------------------------------------------------------------
module tplc_core
    import tplc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  tplc_item_t            item,
    input  logic [CUTOFF_W-1:0]   cutoff_tenths,
    input  logic [INTERVAL_W-1:0] report_interval,
    output tplc_result_t          result_next
);

    localparam int SUM_W = 18;
    localparam logic signed [SUM_W-1:0] COARSE_K = SUM_W'(COARSE_FACTOR);
    localparam logic signed [SUM_W-1:0] MAX_K    = SUM_W'(MAX_CURRENT);
    localparam logic signed [SUM_W-1:0] MIN_K    = SUM_W'(MIN_CURRENT);
    localparam logic signed [TEMP_W-1:0] FAN_ON_T  = TEMP_W'(30 * 16);
    localparam logic signed [TEMP_W-1:0] FAN_OFF_T = TEMP_W'(25 * 16);
    localparam logic [CUTOFF_W-1:0] DEG_SCALE = CUTOFF_W'(10);

    // State; the encoder total always equals the accepted setpoint
    logic                  enabled_reg,  enabled_next;
    logic [CUR_W-1:0]      setpoint_reg, setpoint_next;
    logic                  fan_reg,      fan_next;
    logic                  latch_reg,    latch_next;
    logic                  coarse_reg,   coarse_next;
    logic                  held_reg,     held_next;
    logic [INTERVAL_W-1:0] tick_reg,     tick_next;
    logic                  report;

    logic signed [SUM_W-1:0] set_ma;
    logic signed [SUM_W-1:0] steps_ext;
    logic signed [SUM_W-1:0] steps_scaled;
    logic signed [SUM_W-1:0] enc_sum;
    logic signed [SUM_W-1:0] enc_floor;
    logic [CUTOFF_W-1:0]     deg_a_x10;
    logic [CUTOFF_W-1:0]     deg_b_x10;
    logic                    hot_a, hot_b;
    logic [INTERVAL_W-1:0]   tick_inc;

    // Clamp to the current range, maximum tested first
    function automatic logic [CUR_W-1:0] clamp_current(input logic signed [SUM_W-1:0] v);
        logic [CUR_W-1:0] r;
        if (v > MAX_K) begin
            r = CUR_W'(MAX_CURRENT);
        end else if (v < MIN_K) begin
            r = CUR_W'(MIN_CURRENT);
        end else begin
            r = v[CUR_W-1:0];
        end
        return r;
    endfunction

    // Operand preparation
    assign set_ma       = SUM_W'({2'b00, item.setpoint_ma});
    assign steps_ext    = SUM_W'(item.enc_steps);
    assign steps_scaled = coarse_reg ? (steps_ext * COARSE_K) : steps_ext;
    assign enc_sum      = $signed(SUM_W'({6'b0, setpoint_reg})) + steps_scaled;
    assign enc_floor    = enc_sum[SUM_W-1] ? MIN_K : enc_sum;

    // Whole degrees times ten against the cutoff; negative never trips
    assign deg_a_x10 = CUTOFF_W'({4'b0, item.temp_a[TEMP_W-2:4]}) * DEG_SCALE;
    assign deg_b_x10 = CUTOFF_W'({4'b0, item.temp_b[TEMP_W-2:4]}) * DEG_SCALE;
    assign hot_a     = !item.temp_a[TEMP_W-1] && (deg_a_x10 > cutoff_tenths);
    assign hot_b     = !item.temp_b[TEMP_W-1] && (deg_b_x10 > cutoff_tenths);

    assign tick_inc = tick_reg + INTERVAL_W'(1);

    // Event decode
    always_comb begin
        enabled_next  = enabled_reg;
        setpoint_next = setpoint_reg;
        fan_next      = fan_reg;
        latch_next    = latch_reg;
        coarse_next   = coarse_reg;
        held_next     = held_reg;
        tick_next     = tick_reg;
        report        = 1'b0;
        unique case (item.op)
            OP_TICK: begin
                tick_next = tick_inc;
                if ((report_interval != '0) && (report_interval == tick_inc)) begin
                    tick_next = '0;
                    report    = 1'b1;
                end
            end
            OP_TEMPS: begin
                if ((item.temp_a > FAN_ON_T) || (item.temp_b > FAN_ON_T)) begin
                    fan_next = 1'b1;
                end
                if ((item.temp_a < FAN_OFF_T) && (item.temp_b < FAN_OFF_T)) begin
                    fan_next = 1'b0;
                end
                if (hot_a || hot_b) begin
                    enabled_next = 1'b0;
                    latch_next   = 1'b1;
                end
            end
            OP_SET: begin
                setpoint_next = clamp_current(set_ma);
            end
            OP_ENABLE: begin
                enabled_next = 1'b1;
                latch_next   = 1'b0;
            end
            OP_DISABLE: begin
                enabled_next = 1'b0;
            end
            OP_TOGGLE: begin
                enabled_next = !enabled_reg;
                if (!enabled_reg) begin
                    latch_next = 1'b0;
                end
            end
            OP_STEPS: begin
                setpoint_next = clamp_current(enc_floor);
            end
            OP_HELD: begin
                if (item.held_flag) begin
                    if (!held_reg) begin
                        coarse_next = !coarse_reg;
                        held_next   = 1'b1;
                    end
                end else begin
                    held_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Result reflects the state after the event
    always_comb begin
        result_next.dac_code    = enabled_next ? setpoint_next : '0;
        result_next.set_current = setpoint_next;
        result_next.output_on   = enabled_next;
        result_next.fans_on     = fan_next;
        result_next.emergency   = latch_next;
        result_next.coarse_mode = coarse_next;
        result_next.report_due  = report;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg  <= 1'b0;
            setpoint_reg <= '0;
            fan_reg      <= 1'b0;
            latch_reg    <= 1'b0;
            coarse_reg   <= 1'b1;
            held_reg     <= 1'b0;
            tick_reg     <= '0;
        end else if (step) begin
            enabled_reg  <= enabled_next;
            setpoint_reg <= setpoint_next;
            fan_reg      <= fan_next;
            latch_reg    <= latch_next;
            coarse_reg   <= coarse_next;
            held_reg     <= held_next;
            tick_reg     <= tick_next;
        end
    end

endmodule

### sv/thermal_protected_load_controller.sv
// Path: an accepted event word waits in the input register; its result word
// then waits in the result register.
// Throughput: one event word per cycle unless m_tready stalls results; the whole
// state update is one pass of logic between the input and result registers.
// Reset (aresetn low, synchronous): state and both stages clear, configuration
// returns to cutoff 600 tenths and report interval 100.
// ----------------------------------------------------------------------------
// thermal_protected_load_controller: event-driven electronic load controller
// Stream in one event word, stream out one status word per event; thermal
// shutdown, fan hysteresis, setpoint clamping, encoder scaling and reporting.
// ----------------------------------------------------------------------------
module thermal_protected_load_controller
    import tplc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // event channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // temp_a[11:0], temp_b[23:12], setpoint_ma[39:24], enc_steps[47:40],
    // held_flag[48], zero[55:49]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  logic [OP_W-1:0]       s_tuser,
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // dac_code[11:0], set_current[23:12], output_on[24], fans_on[25],
    // emergency[26], coarse_mode[27], report_due[28], zero[31:29]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic                  in_valid_reg;
    tplc_item_t            in_item_reg;
    tplc_item_t            in_item;
    logic                  out_valid_reg;
    tplc_result_t          result_reg;
    tplc_result_t          result_next;
    logic [CUTOFF_W-1:0]   cutoff_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic                  s_accept;
    logic                  advance;

    // Unpack the event word
    always_comb begin
        in_item.op          = s_tuser;
        in_item.temp_a      = s_tdata[11:0];
        in_item.temp_b      = s_tdata[23:12];
        in_item.setpoint_ma = s_tdata[39:24];
        in_item.enc_steps   = s_tdata[47:40];
        in_item.held_flag   = s_tdata[48];
    end

    // Handshake: the input stage drains whenever the result stage is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg   <= CUTOFF_RESET;
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_CUTOFF) begin
                cutoff_reg <= cfg_wdata[CUTOFF_W-1:0];
            end
            if (cfg_addr == CFG_INTERVAL) begin
                interval_reg <= cfg_wdata[INTERVAL_W-1:0];
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= in_item;
        end
    end

    // State update
    tplc_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .item            (in_item_reg),
        .cutoff_tenths   (cutoff_reg),
        .report_interval (interval_reg),
        .result_next     (result_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, result_reg.report_due, result_reg.coarse_mode,
                       result_reg.emergency, result_reg.fans_on, result_reg.output_on,
                       result_reg.set_current, result_reg.dac_code};

`ifndef SYNTHESIS
    // Drive code follows the setpoint only while the output is on
    a_dac_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (result_reg.dac_code ==
                           (result_reg.output_on ? result_reg.set_current : '0)))
        else $error("dac_code inconsistent with output_on/set_current");

    // A latched shutdown never coexists with an enabled output
    a_latch_off: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(result_reg.emergency && result_reg.output_on))
        else $error("emergency latched while output on");

    // Setpoint stays within the current range
    a_set_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (result_reg.set_current <= CUR_W'(MAX_CURRENT)))
        else $error("set_current above maximum");

    // Only tick events can raise a report
    a_report_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_item_reg.op != OP_TICK)) |=> !result_reg.report_due)
        else $error("report_due on a non-tick event");
`endif

endmodule

### tb/tb_thermal_protected_load_controller.sv
// ----------------------------------------------------------------------------
// tb_thermal_protected_load_controller: self-checking bench for the load controller
// Streams event words into the controller and predicts every status word from
// its own copy of the controller state and registers. Each status word is
// checked field by field against the oldest prediction. A directed sequence
// covers the limits and the thermal, clamping and mode corner cases. Random
// phases follow under several register settings and back-pressure patterns,
// then the report interval is lowered under the tick count so that no early
// report may appear.
// ----------------------------------------------------------------------------
module tb_thermal_protected_load_controller;
    import tplc_pkg::*;

    // Unused register index, writes there must have no effect
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    // Fan hysteresis points in sixteenths of a degree
    localparam int FAN_ON_T16  = 30 * 16;
    localparam int FAN_OFF_T16 = 25 * 16;

    localparam int MAX_REPORTS = 40;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = OP_TICK;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_CUTOFF;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    thermal_protected_load_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow registers and controller state
    logic [CUTOFF_W-1:0]   cut_tenths   = CUTOFF_RESET;
    logic [INTERVAL_W-1:0] rep_interval = INTERVAL_RESET;
    logic                  load_on      = 1'b0;
    logic [CUR_W-1:0]      set_ma       = '0;
    int                    enc_total    = 0;
    logic                  fans         = 1'b0;
    logic                  tripped      = 1'b0;
    logic                  coarse_sel   = 1'b1;
    logic                  held_seen    = 1'b0;
    logic [INTERVAL_W-1:0] ticks        = '0;

    tplc_item_t   event_backlog[$];
    tplc_result_t status_due[$];
    tplc_item_t   in_flight;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           faults        = 0;

    // Clamp a requested current and take it as both setpoint and encoder total
    function automatic void take_current(input int ma);
        if (ma > MAX_CURRENT)
            ma = MAX_CURRENT;
        else if (ma < MIN_CURRENT)
            ma = MIN_CURRENT;
        set_ma    = ma[CUR_W-1:0];
        enc_total = ma;
    endfunction

    // Whole degrees times ten above the cutoff; negatives never trip
    function automatic logic too_hot(input int t16);
        return t16 >= 0 && (t16 / 16) * 10 > int'(cut_tenths);
    endfunction

    // Advance the shadow state by one event and queue the status it gives
    function automatic void predict_status(input tplc_item_t ev);
        tplc_result_t st;
        int           ta;
        int           tb;
        int           total;
        logic         pulse;
        pulse = 1'b0;
        ta = int'(ev.temp_a);
        tb = int'(ev.temp_b);
        case (ev.op)
            OP_TICK: begin
                ticks = ticks + 1'b1;
                if (rep_interval != 0 && rep_interval == ticks) begin
                    ticks = '0;
                    pulse = 1'b1;
                end
            end
            OP_TEMPS: begin
                if (ta > FAN_ON_T16 || tb > FAN_ON_T16)
                    fans = 1'b1;
                if (ta < FAN_OFF_T16 && tb < FAN_OFF_T16)
                    fans = 1'b0;
                if (too_hot(ta) || too_hot(tb)) begin
                    load_on = 1'b0;
                    tripped = 1'b1;
                end
            end
            OP_SET: take_current(int'(ev.setpoint_ma));
            OP_ENABLE: begin
                load_on = 1'b1;
                tripped = 1'b0;
            end
            OP_DISABLE: load_on = 1'b0;
            OP_TOGGLE: begin
                load_on = !load_on;
                if (load_on)
                    tripped = 1'b0;
            end
            OP_STEPS: begin
                total = enc_total + (coarse_sel ? int'(ev.enc_steps) * COARSE_FACTOR
                                                : int'(ev.enc_steps));
                if (total < 0)
                    total = MIN_CURRENT;
                take_current(total);
            end
            OP_HELD: begin
                if (ev.held_flag) begin
                    if (!held_seen) begin
                        coarse_sel = !coarse_sel;
                        held_seen  = 1'b1;
                    end
                end else begin
                    held_seen = 1'b0;
                end
            end
            default: ;
        endcase
        st.dac_code    = load_on ? set_ma : '0;
        st.set_current = set_ma;
        st.output_on   = load_on;
        st.fans_on     = fans;
        st.emergency   = tripped;
        st.coarse_mode = coarse_sel;
        st.report_due  = pulse;
        status_due.push_back(st);
    endfunction

    // Temperatures bunched round the fan points and the current cutoff
    function automatic logic signed [TEMP_W-1:0] pick_temp();
        int r;
        int v;
        r = $urandom_range(9);
        if (r < 4) begin
            v = $urandom_range(530, 350);
        end else if (r < 6) begin
            v = int'(cut_tenths) * 16 / 10 + int'($urandom_range(80)) - 40;
            if (v > 2047)
                v = 2047;
        end else begin
            v = $urandom;
        end
        return v[TEMP_W-1:0];
    endfunction

    // Random event; fields the operation does not use stay fully random
    function automatic tplc_item_t random_event();
        tplc_item_t    ev;
        logic [63:0]   raw;
        int            pick;
        raw  = {$urandom, $urandom};
        ev   = raw[$bits(tplc_item_t)-1:0];
        pick = $urandom_range(99);
        if (pick < 25) begin
            ev.op = OP_TICK;
        end else if (pick < 45) begin
            ev.op     = OP_TEMPS;
            ev.temp_a = pick_temp();
            ev.temp_b = pick_temp();
        end else if (pick < 53) begin
            ev.op = OP_SET;
            case ($urandom_range(4))
                0, 1: ev.setpoint_ma = MA_W'($urandom_range(4095));
                2:    ev.setpoint_ma = MA_W'($urandom_range(4010, 3990));
                default: ;
            endcase
        end else if (pick < 60) begin
            ev.op = OP_ENABLE;
        end else if (pick < 65) begin
            ev.op = OP_DISABLE;
        end else if (pick < 72) begin
            ev.op = OP_TOGGLE;
        end else if (pick < 88) begin
            ev.op = OP_STEPS;
        end else begin
            ev.op = OP_HELD;
        end
        return ev;
    endfunction

    task automatic push_ev(input logic [OP_W-1:0] op, input int ta, input int tb,
                           input int ma, input int steps, input logic held);
        tplc_item_t ev;
        ev.op          = op;
        ev.temp_a      = ta[TEMP_W-1:0];
        ev.temp_b      = tb[TEMP_W-1:0];
        ev.setpoint_ma = ma[MA_W-1:0];
        ev.enc_steps   = steps[STEP_W-1:0];
        ev.held_flag   = held;
        event_backlog.push_back(ev);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_CUTOFF:   cut_tenths   = val[CUTOFF_W-1:0];
            CFG_INTERVAL: rep_interval = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every word is sent and every status word has come back
    task automatic settle();
        do
            @(negedge aclk);
        while (event_backlog.size() != 0 || s_tvalid || status_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] cut_word,
                             input logic [CFG_DATA_W-1:0] ivl,
                             input int snd, input int rcv, input int count);
        settle();
        write_reg(CFG_CUTOFF, cut_word);
        write_reg(CFG_SPARE, ~cut_word);
        write_reg(CFG_INTERVAL, ivl);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        repeat (count) event_backlog.push_back(random_event());
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    // Event driver: holds the word until taken, idles at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_status(in_flight);
            if (!s_tvalid || s_tready) begin
                if (event_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = event_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, in_flight.held_flag, in_flight.enc_steps,
                                 in_flight.setpoint_ma, in_flight.temp_b, in_flight.temp_a};
                    s_tuser  <= in_flight.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Status monitor: random back-pressure, field-by-field compare
    always @(posedge aclk) begin
        tplc_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (status_due.size() == 0) begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("%0t: unexpected status word, expected none, actual %h",
                                 $time, m_tdata);
                end else begin
                    want = status_due.pop_front();
                    if (m_tdata[11:0] !== want.dac_code)
                        note_mismatch("dac_code", int'(want.dac_code),
                                      int'(m_tdata[11:0]));
                    if (m_tdata[23:12] !== want.set_current)
                        note_mismatch("set_current", int'(want.set_current),
                                      int'(m_tdata[23:12]));
                    if (m_tdata[24] !== want.output_on)
                        note_mismatch("output_on", int'(want.output_on), int'(m_tdata[24]));
                    if (m_tdata[25] !== want.fans_on)
                        note_mismatch("fans_on", int'(want.fans_on), int'(m_tdata[25]));
                    if (m_tdata[26] !== want.emergency)
                        note_mismatch("emergency", int'(want.emergency), int'(m_tdata[26]));
                    if (m_tdata[27] !== want.coarse_mode)
                        note_mismatch("coarse_mode", int'(want.coarse_mode),
                                      int'(m_tdata[27]));
                    if (m_tdata[28] !== want.report_due)
                        note_mismatch("report_due", int'(want.report_due),
                                      int'(m_tdata[28]));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        tplc_item_t ev;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 15;
        recv_idle_pct = 64;

        // Directed: setpoint clamps, encoder scaling, mode latch, thermal, enable and toggle paths
        push_ev(OP_TICK,     0,     0,     0,    0, 1'b0);
        push_ev(OP_SET,      0,     0, 65535,    0, 1'b0);
        push_ev(OP_SET,      0,     0,     0,    0, 1'b0);
        push_ev(OP_SET,      0,     0,  4095,    0, 1'b0);
        push_ev(OP_SET,      0,     0,  2500,    0, 1'b0);
        push_ev(OP_ENABLE,   0,     0,     0,    0, 1'b0);
        push_ev(OP_STEPS,    0,     0,     0,  127, 1'b0);
        push_ev(OP_STEPS,    0,     0,     0,  127, 1'b0);
        push_ev(OP_STEPS,    0,     0,     0, -128, 1'b0);
        push_ev(OP_HELD,     0,     0,     0,    0, 1'b1);
        push_ev(OP_HELD,     0,     0,     0,    0, 1'b1);
        push_ev(OP_HELD,     0,     0,     0,    0, 1'b0);
        push_ev(OP_STEPS,    0,     0,     0, -128, 1'b0);
        push_ev(OP_TEMPS,  481,     0,     0,    0, 1'b0);
        push_ev(OP_TEMPS,  400,   400,     0,    0, 1'b0);
        push_ev(OP_TEMPS,  399, -2048,     0,    0, 1'b0);
        push_ev(OP_TEMPS, -2048,   -1,     0,    0, 1'b0);
        push_ev(OP_TEMPS,  960,   975,     0,    0, 1'b0);
        push_ev(OP_TEMPS,    0,   976,     0,    0, 1'b0);
        push_ev(OP_TOGGLE,   0,     0,     0,    0, 1'b0);
        push_ev(OP_TOGGLE,   0,     0,     0,    0, 1'b0);
        push_ev(OP_DISABLE,  0,     0,     0,    0, 1'b0);
        push_ev(OP_TEMPS, 2047,  2047,     0,    0, 1'b0);
        push_ev(OP_SET,      0,     0,   100,    0, 1'b0);
        push_ev(OP_HELD,     0,     0,     0,    0, 1'b1);
        push_ev(OP_STEPS,    0,     0,     0, -128, 1'b0);
        push_ev(OP_ENABLE,   0,     0,     0,    0, 1'b0);

        // Random phases across register settings and back-pressure patterns
        run_phase(16'd0,     16'd1,     15, 64, 200);
        run_phase(16'd1250,  16'd3,     15, 64, 230);
        run_phase(16'd2047,  16'd0,     64, 15, 230);
        run_phase(16'hFA71,  16'd65535, 64, 15, 200);
        run_phase(16'd313,   16'd7,      0,  0, 230);
        run_phase(16'd1000,  16'd2,      0,  0, 230);

        // Lower the interval under the count; no report until the counter wraps
        settle();
        write_reg(CFG_INTERVAL, 16'd100);
        repeat (50) begin
            ev    = random_event();
            ev.op = OP_TICK;
            event_backlog.push_back(ev);
        end
        settle();
        write_reg(CFG_INTERVAL, 16'd10);
        repeat (30) begin
            ev    = random_event();
            ev.op = OP_TICK;
            event_backlog.push_back(ev);
        end
        settle();

        if (faults == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #12000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
